// File: rtl/mrfb_pkg.sv
// Package for the report frame builder: payload structs, byte sequence codes,
// frame constants and the byte-wide CRC-16/MODBUS update.
// No dependencies.
`default_nettype none

package mrfb_pkg;

	typedef struct packed {
		logic [15:0] reg_address;
		logic [6:0]  word_count;
		logic [15:0] word_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} out_item_t;

	// Which byte of the frame goes out next
	typedef enum logic [10:0] {
		S_HDR_DEV  = 11'b000_0000_0001,
		S_HDR_FUNC = 11'b000_0000_0010,
		S_HDR_AHI  = 11'b000_0000_0100,
		S_HDR_ALO  = 11'b000_0000_1000,
		S_HDR_ZERO = 11'b000_0001_0000,
		S_HDR_CNT  = 11'b000_0010_0000,
		S_HDR_BCNT = 11'b000_0100_0000,
		S_WORD_HI  = 11'b000_1000_0000,
		S_WORD_LO  = 11'b001_0000_0000,
		S_CRC_LO   = 11'b010_0000_0000,
		S_CRC_HI   = 11'b100_0000_0000
	} seq_t;

	localparam logic [7:0]  FUNC_CODE   = 8'h46;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  DEV_RESET   = 8'h01;
	localparam logic        REG_DEV_ADR = 1'b0;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/modbus_report_frame_builder_top.sv
// Report frame builder: turns data words into a serial byte stream with CRC.
// Depends on mrfb_pkg.
`default_nettype none

// One input item is held in an input register while a byte sequencer sends its
// bytes through the output register, one byte per cycle, with the CRC-16/MODBUS
// updated on each byte. An item inside a frame sends its word bytes, plus the
// CRC when it is the last word; the frame-opening item sends 7 header bytes,
// the first word unless the word count is zero, then the CRC if the frame ends.
// The next item is taken in the cycle its predecessor's last byte is loaded,
// so a stream of words runs at one byte per cycle as long as out_stall stays
// low. device_address lies at byte address 0 of the APB port and resets to 1.
module modbus_report_frame_builder_top (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire [2:0]           paddr,
	input  wire [31:0]          pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  wire                 in_valid,
	output logic                in_stall,
	input  mrfb_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  wire                 out_stall,
	output mrfb_pkg::out_item_t out_item
);

	logic [7:0]          dev_addr_q;
	mrfb_pkg::in_item_t  item_s1;
	logic                item_valid_q;
	mrfb_pkg::seq_t      seq_q;
	mrfb_pkg::seq_t      seq_next;
	logic [15:0]         crc_q;
	logic                frame_open_q;
	logic                frame_open_next;
	logic [6:0]          words_left_q;
	logic                out_valid_q;
	mrfb_pkg::out_item_t out_item_q;
	logic                out_free;
	logic                load;
	logic                item_done;
	logic                accept;
	logic [7:0]          cur_byte;
	logic                cur_is_crc;
	logic                last_word;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == mrfb_pkg::REG_DEV_ADR) ? {24'h0, dev_addr_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= mrfb_pkg::DEV_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == mrfb_pkg::REG_DEV_ADR) begin
			dev_addr_q <= pwdata[7:0];
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign load      = item_valid_q && out_free;
	assign last_word = (words_left_q == 7'd1);

	always_comb begin
		cur_byte   = 8'h00;
		cur_is_crc = 1'b0;
		seq_next   = seq_q;
		item_done  = 1'b0;
		unique case (seq_q)
			mrfb_pkg::S_HDR_DEV: begin
				cur_byte = dev_addr_q;
				seq_next = mrfb_pkg::S_HDR_FUNC;
			end
			mrfb_pkg::S_HDR_FUNC: begin
				cur_byte = mrfb_pkg::FUNC_CODE;
				seq_next = mrfb_pkg::S_HDR_AHI;
			end
			mrfb_pkg::S_HDR_AHI: begin
				cur_byte = item_s1.reg_address[15:8];
				seq_next = mrfb_pkg::S_HDR_ALO;
			end
			mrfb_pkg::S_HDR_ALO: begin
				cur_byte = item_s1.reg_address[7:0];
				seq_next = mrfb_pkg::S_HDR_ZERO;
			end
			mrfb_pkg::S_HDR_ZERO: begin
				cur_byte = 8'h00;
				seq_next = mrfb_pkg::S_HDR_CNT;
			end
			mrfb_pkg::S_HDR_CNT: begin
				cur_byte = {1'b0, item_s1.word_count};
				seq_next = mrfb_pkg::S_HDR_BCNT;
			end
			mrfb_pkg::S_HDR_BCNT: begin
				cur_byte = {item_s1.word_count, 1'b0};
				seq_next = (item_s1.word_count == 7'd0) ? mrfb_pkg::S_CRC_LO
					: mrfb_pkg::S_WORD_HI;
			end
			mrfb_pkg::S_WORD_HI: begin
				cur_byte = item_s1.word_value[15:8];
				seq_next = mrfb_pkg::S_WORD_LO;
			end
			mrfb_pkg::S_WORD_LO: begin
				cur_byte = item_s1.word_value[7:0];
				if (last_word) begin
					seq_next = mrfb_pkg::S_CRC_LO;
				end else begin
					item_done = 1'b1;
				end
			end
			mrfb_pkg::S_CRC_LO: begin
				cur_byte   = crc_q[7:0];
				cur_is_crc = 1'b1;
				seq_next   = mrfb_pkg::S_CRC_HI;
			end
			mrfb_pkg::S_CRC_HI: begin
				cur_byte   = crc_q[15:8];
				cur_is_crc = 1'b1;
				item_done  = 1'b1;
			end
			default: begin
				cur_byte = 8'h00;
			end
		endcase
	end

	// Frame state as it stands once this cycle's byte is loaded
	always_comb begin
		frame_open_next = frame_open_q;
		if (load) begin
			if (seq_q == mrfb_pkg::S_HDR_BCNT && item_s1.word_count != 7'd0) begin
				frame_open_next = 1'b1;
			end else if (seq_q == mrfb_pkg::S_CRC_HI) begin
				frame_open_next = 1'b0;
			end
		end
	end

	assign in_stall = item_valid_q && !(load && item_done);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
			seq_q        <= mrfb_pkg::S_HDR_DEV;
			crc_q        <= mrfb_pkg::CRC_INIT;
			frame_open_q <= 1'b0;
			words_left_q <= 7'd0;
		end else begin
			frame_open_q <= frame_open_next;
			if (load) begin
				if (seq_q == mrfb_pkg::S_HDR_DEV) begin
					crc_q <= mrfb_pkg::crc_byte(mrfb_pkg::CRC_INIT, cur_byte);
				end else if (seq_q == mrfb_pkg::S_CRC_HI) begin
					crc_q <= mrfb_pkg::CRC_INIT;
				end else if (!cur_is_crc) begin
					crc_q <= mrfb_pkg::crc_byte(crc_q, cur_byte);
				end
				if (seq_q == mrfb_pkg::S_HDR_BCNT) begin
					words_left_q <= item_s1.word_count;
				end else if (seq_q == mrfb_pkg::S_WORD_LO) begin
					words_left_q <= words_left_q - 7'd1;
				end
			end
			if (accept) begin
				item_valid_q <= 1'b1;
				seq_q        <= frame_open_next ? mrfb_pkg::S_WORD_HI : mrfb_pkg::S_HDR_DEV;
			end else if (load) begin
				seq_q <= seq_next;
				if (item_done) begin
					item_valid_q <= 1'b0;
				end
			end
		end
	end

	// Input payload register
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q.out_byte  <= cur_byte;
			out_item_q.last_byte <= (seq_q == mrfb_pkg::S_CRC_HI);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef ASSERT_OFF
	a_seq_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(seq_q))
		else $error("byte sequence code not one-hot");

	a_closed_no_words: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_open_q |-> words_left_q == 7'd0)
		else $error("words pending outside an open frame");

	a_crc_hi_closes: assert property (@(posedge clk) disable iff (!arst_n)
		load && seq_q == mrfb_pkg::S_CRC_HI |=> !frame_open_q && crc_q == mrfb_pkg::CRC_INIT)
		else $error("frame not closed after CRC");

	a_last_word_crc: assert property (@(posedge clk) disable iff (!arst_n)
		load && seq_q == mrfb_pkg::S_WORD_LO && last_word |=> seq_q == mrfb_pkg::S_CRC_LO)
		else $error("CRC not appended after last word");

	a_last_marks_crc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.last_byte |-> !frame_open_q || item_valid_q)
		else $error("last byte flagged inside an open frame");
`endif

endmodule

`default_nettype wire
